### rtl/midi_pkg.sv
// ----------------------------------------------------------------------------
// MIDI parser package
// Parser state encoding, action codes, status byte and controller number constants.
// ----------------------------------------------------------------------------
package midi_pkg;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_TRIPLE1 = 3'd1,
        ST_TRIPLE2 = 3'd2,
        ST_DOUBLE1 = 3'd3,
        ST_SYSEX   = 3'd4
    } t_parse_state;

    typedef enum logic [2:0] {
        ACT_NOTE_ON       = 3'd0,
        ACT_NOTE_OFF      = 3'd1,
        ACT_CONTROLLER    = 3'd2,
        ACT_RESET_ALL     = 3'd3,
        ACT_ALL_NOTES_OFF = 3'd4,
        ACT_PROGRAM       = 3'd5,
        ACT_PRESSURE      = 3'd6,
        ACT_PITCH_BEND    = 3'd7
    } t_action;

    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_CONTROL    = 4'hb;
    localparam logic [3:0] HI_PROGRAM    = 4'hc;
    localparam logic [3:0] HI_PRESSURE   = 4'hd;
    localparam logic [3:0] HI_BEND       = 4'he;
    localparam logic [3:0] HI_SYSTEM     = 4'hf;

    localparam logic [7:0] SYS_SYSEX     = 8'hf0;
    localparam logic [7:0] SYS_MTC       = 8'hf1;
    localparam logic [7:0] SYS_SONG_POS  = 8'hf2;
    localparam logic [7:0] SYS_SONG_SEL  = 8'hf3;
    localparam logic [7:0] SYS_TUNE      = 8'hf6;
    localparam logic [7:0] SYS_EOX       = 8'hf7;
    localparam logic [7:0] RT_CLOCK      = 8'hf8;
    localparam logic [7:0] RT_START      = 8'hfa;
    localparam logic [7:0] RT_CONTINUE   = 8'hfb;
    localparam logic [7:0] RT_STOP       = 8'hfc;
    localparam logic [7:0] RT_SENSE      = 8'hfe;
    localparam logic [7:0] RT_RESET      = 8'hff;

    localparam logic [6:0] CC_BANK       = 7'h00;
    localparam logic [6:0] CC_VOLUME     = 7'h07;
    localparam logic [6:0] CC_BANK_LSB   = 7'h20;
    localparam logic [6:0] CC_RESET_ALL  = 7'h79;
    localparam logic [6:0] CC_NOTES_OFF  = 7'h7b;

endpackage

### rtl/midi_byte_stream_parser_top.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Decodes a raw MIDI byte stream into channel voice actions.
// ----------------------------------------------------------------------------
// One word is taken per cycle unless stalled; a completed message is written
// into the output register when its last byte is accepted. The only limit on
// rate is the single output register: input stalls only while a result waits
// and the output side stalls. No running status; sysex data is dropped.
module midi_byte_stream_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_midi_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_action,
    output logic [3:0]  o_channel,
    output logic [6:0]  o_first_value,
    output logic [13:0] o_second_value
);

    midi_pkg::t_parse_state r_state, n_state;
    logic [7:0]  r_status, n_status;
    logic [6:0]  r_first_data, n_first_data;
    logic        r_out_valid;
    logic [2:0]  r_action;
    logic [3:0]  r_channel;
    logic [6:0]  r_first_value;
    logic [13:0] r_second_value;

    logic        w_accept;
    logic        w_hit;
    logic [2:0]  w_action;
    logic [6:0]  w_first_value;
    logic [13:0] w_second_value;
    logic [6:0]  w_data;
    logic [3:0]  w_hi;

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign w_data   = i_midi_byte[6:0];
    assign w_hi     = r_status[7:4];

    // next state
    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_first_data = r_first_data;
        if (i_midi_byte[7]) begin
            if (i_midi_byte[7:4] != midi_pkg::HI_SYSTEM) begin
                n_status = i_midi_byte;
                if (i_midi_byte[7:4] == midi_pkg::HI_PROGRAM ||
                    i_midi_byte[7:4] == midi_pkg::HI_PRESSURE) begin
                    n_state = midi_pkg::ST_DOUBLE1;
                end else begin
                    n_state = midi_pkg::ST_TRIPLE1;
                end
            end else begin
                case (i_midi_byte)
                    midi_pkg::SYS_SYSEX: begin
                        n_state = midi_pkg::ST_SYSEX;
                    end
                    midi_pkg::SYS_MTC, midi_pkg::SYS_SONG_SEL: begin
                        n_status = i_midi_byte;
                        n_state  = midi_pkg::ST_DOUBLE1;
                    end
                    midi_pkg::SYS_SONG_POS: begin
                        n_status = i_midi_byte;
                        n_state  = midi_pkg::ST_TRIPLE1;
                    end
                    default: begin
                        if (i_midi_byte inside {midi_pkg::SYS_TUNE, midi_pkg::SYS_EOX,
                                                midi_pkg::RT_CLOCK, midi_pkg::RT_START,
                                                midi_pkg::RT_CONTINUE, midi_pkg::RT_STOP,
                                                midi_pkg::RT_SENSE, midi_pkg::RT_RESET}) begin
                            n_state = midi_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
        end else begin
            case (r_state)
                midi_pkg::ST_TRIPLE1: begin
                    n_first_data = w_data;
                    n_state      = midi_pkg::ST_TRIPLE2;
                end
                midi_pkg::ST_SYSEX: n_state = midi_pkg::ST_SYSEX;
                default:            n_state = midi_pkg::ST_IDLE;
            endcase
        end
    end

    // result decode
    always_comb begin
        w_hit          = 1'b0;
        w_action       = midi_pkg::ACT_NOTE_ON;
        w_first_value  = '0;
        w_second_value = '0;
        if (!i_midi_byte[7]) begin
            case (r_state)
                midi_pkg::ST_TRIPLE2: begin
                    case (w_hi)
                        midi_pkg::HI_NOTE_OFF: begin
                            w_hit         = 1'b1;
                            w_action      = midi_pkg::ACT_NOTE_OFF;
                            w_first_value = r_first_data;
                        end
                        midi_pkg::HI_NOTE_ON: begin
                            w_hit          = 1'b1;
                            w_action       = midi_pkg::ACT_NOTE_ON;
                            w_first_value  = r_first_data;
                            w_second_value = {7'd0, w_data};
                        end
                        midi_pkg::HI_CONTROL: begin
                            if (r_first_data == midi_pkg::CC_BANK ||
                                r_first_data == midi_pkg::CC_VOLUME ||
                                r_first_data == midi_pkg::CC_BANK_LSB) begin
                                w_hit          = 1'b1;
                                w_action       = midi_pkg::ACT_CONTROLLER;
                                w_first_value  = r_first_data;
                                w_second_value = {7'd0, w_data};
                            end else if (r_first_data == midi_pkg::CC_RESET_ALL) begin
                                w_hit    = 1'b1;
                                w_action = midi_pkg::ACT_RESET_ALL;
                            end else if (r_first_data == midi_pkg::CC_NOTES_OFF) begin
                                w_hit    = 1'b1;
                                w_action = midi_pkg::ACT_ALL_NOTES_OFF;
                            end
                        end
                        midi_pkg::HI_BEND: begin
                            w_hit          = 1'b1;
                            w_action       = midi_pkg::ACT_PITCH_BEND;
                            w_second_value = {w_data, r_first_data};
                        end
                        default: w_hit = 1'b0;
                    endcase
                end
                midi_pkg::ST_DOUBLE1: begin
                    case (w_hi)
                        midi_pkg::HI_PROGRAM: begin
                            w_hit         = 1'b1;
                            w_action      = midi_pkg::ACT_PROGRAM;
                            w_first_value = w_data;
                        end
                        midi_pkg::HI_PRESSURE: begin
                            w_hit         = 1'b1;
                            w_action      = midi_pkg::ACT_PRESSURE;
                            w_first_value = w_data;
                        end
                        default: w_hit = 1'b0;
                    endcase
                end
                default: w_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= midi_pkg::ST_IDLE;
            r_status     <= '0;
            r_first_data <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state      <= n_state;
                r_status     <= n_status;
                r_first_data <= n_first_data;
            end
            if (w_accept && w_hit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_hit) begin
            r_action       <= w_action;
            r_channel      <= r_status[3:0];
            r_first_value  <= w_first_value;
            r_second_value <= w_second_value;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_action       = r_action;
    assign o_channel      = r_channel;
    assign o_first_value  = r_first_value;
    assign o_second_value = r_second_value;

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending result");

    a_status_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_midi_byte[7]) |=> !o_valid)
        else $error("status word produced a result");

    a_first_data_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_midi_byte[7] && r_state == midi_pkg::ST_TRIPLE1)
        |=> (r_state == midi_pkg::ST_TRIPLE2))
        else $error("first data word did not advance parser");

    a_bend_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_action == midi_pkg::ACT_PITCH_BEND) |-> (o_first_value == 7'd0))
        else $error("pitch bend with nonzero first value");

endmodule
